// File: rtl/core/mrfe_pkg.sv
// shared types and constants of the mesh refinement front engine
// no dependencies
package mrfe_pkg;

  localparam int IDX_W    = 12;
  localparam int SPL_IN_W = 11;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 2;
  localparam int DEP_W    = 13;
  localparam logic [DEP_W-1:0] DEP_MAX = 13'h1fff;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_SPLIT  = 3'd0,
    REQ_LOAD_VERTEX = 3'd1,
    REQ_REFINE      = 3'd2,
    REQ_COARSEN     = 3'd3,
    REQ_QUERY       = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_SAME    = 2'd1,
    STAT_BLOCKED = 2'd2,
    STAT_LIMIT   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TGT_PARENT = 2'd0,
    TGT_LEFT   = 2'd1,
    TGT_RIGHT  = 2'd2,
    TGT_CHILD  = 2'd3
  } tgt_t;

endpackage

// File: rtl/core/mrfe_reduce.sv
// index reduction unit: registered remainder by a constant through reciprocal multiplication
// depends on mrfe_pkg
module mrfe_reduce #(
  parameter int DIVISOR = 4096,
  parameter int LANES   = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mrfe_pkg::IDX_W-1:0] x [LANES],
  output logic                       done,
  output logic [mrfe_pkg::IDX_W-1:0] y [LANES]
);
  import mrfe_pkg::*;

  localparam int     SH    = IDX_W + $clog2(DIVISOR);
  localparam longint RCP   = ((longint'(1) << SH) + DIVISOR - 1) / DIVISOR;
  localparam int     RCP_W = IDX_W + 2;
  localparam int     PW    = IDX_W + RCP_W;

  logic             done_r;
  logic [IDX_W-1:0] rem_r [LANES];

  // floor(v / DIVISOR) is exact for every IDX_W-bit v with this reciprocal
  function automatic logic [IDX_W-1:0] reduce_one(input logic [IDX_W-1:0] v);
    logic [PW-1:0]    prod;
    logic [IDX_W-1:0] q;
    logic [PW-1:0]    back;
    prod = PW'(v) * PW'(RCP);
    q    = IDX_W'(prod >> SH);
    back = PW'(q) * PW'(DIVISOR);
    return IDX_W'(PW'(v) - back);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
    for (int i = 0; i < LANES; i++) begin
      if (start) begin
        rem_r[i] <= reduce_one(x[i]);
      end
    end
  end

  assign done = done_r;
  assign y    = rem_r;

endmodule

// File: rtl/core/mesh_refinement_front_engine_top.sv
// mesh refinement front engine: split table, vertex table and request sequencer
// depends on mrfe_pkg and mrfe_reduce
//
// One request is handled at a time. Every request first reduces its indices to
// the table depths, then reads and writes one or both of two tables,
// each with one write port and one registered read port. Refine and coarsen
// visit the vertices of the split one by one, and an ancestor query repeats a
// split read and a vertex read per parent step. The next transfer can be taken
// in the same cycle as the result appears, and a result held back by out_ready
// stalls the following request in its last step. After reset a clearing pass
// zeroes every entry of both tables before the first transfer.
module mesh_refinement_front_engine_top #(
  parameter int MAX_VERTICES = 4096,
  parameter int MAX_SPLITS   = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mrfe_pkg::REQ_W-1:0]    in_req_type,
  input  logic [mrfe_pkg::SPL_IN_W-1:0] in_split_index,
  input  logic [mrfe_pkg::IDX_W-1:0]    in_vertex_index,
  input  logic [mrfe_pkg::IDX_W-1:0]    in_parent_vertex,
  input  logic [mrfe_pkg::IDX_W-1:0]    in_left_vertex,
  input  logic [mrfe_pkg::IDX_W-1:0]    in_right_vertex,
  input  logic                          in_right_present,
  input  logic [mrfe_pkg::IDX_W-1:0]    in_child_vertex,
  input  logic [mrfe_pkg::SPL_IN_W-1:0] in_removing_split,
  input  logic                          in_has_removing_split,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mrfe_pkg::STAT_W-1:0]   out_status,
  output logic [mrfe_pkg::IDX_W-1:0]    out_ancestor_vertex
);
  import mrfe_pkg::*;

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int SW     = $clog2(MAX_SPLITS);
  localparam int STEP_W = $clog2(MAX_SPLITS + 1);
  localparam int CLR_N  = (MAX_VERTICES > MAX_SPLITS) ? MAX_VERTICES : MAX_SPLITS;
  localparam int CLR_W  = $clog2(CLR_N);

  typedef struct packed {
    logic [VW-1:0] parent;
    logic [VW-1:0] left;
    logic [VW-1:0] right;
    logic [VW-1:0] child;
    logic          rv;
    logic          refined;
  } srec_t;

  typedef struct packed {
    logic             rem_valid;
    logic [SW-1:0]    rem_idx;
    logic             active;
    logic [DEP_W-1:0] dep;
  } vrec_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RED, S_SRD, S_SDEC, S_VRD, S_VCHK, S_SWR, S_DONE
  } state_t;

  // tables
  srec_t smem [MAX_SPLITS];
  vrec_t vmem [MAX_VERTICES];

  logic          s_we, v_we;
  logic [SW-1:0] s_wa, s_ra;
  logic [VW-1:0] v_wa, v_ra;
  srec_t         s_wd, s_rd_r;
  vrec_t         v_wd, v_rd_r;

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_wa] <= s_wd;
    end
    s_rd_r <= smem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_wa] <= v_wd;
    end
    v_rd_r <= vmem[v_ra];
  end

  // index reduction
  logic             red_start, red_done, red_s_done;
  logic [IDX_W-1:0] v_x [5];
  logic [IDX_W-1:0] v_y [5];
  logic [IDX_W-1:0] s_x [2];
  logic [IDX_W-1:0] s_y [2];

  assign red_start = in_valid && in_ready;
  assign v_x[0] = in_vertex_index;
  assign v_x[1] = in_parent_vertex;
  assign v_x[2] = in_left_vertex;
  assign v_x[3] = in_right_vertex;
  assign v_x[4] = in_child_vertex;
  assign s_x[0] = IDX_W'(in_split_index);
  assign s_x[1] = IDX_W'(in_removing_split);

  mrfe_reduce #(.DIVISOR(MAX_VERTICES), .LANES(5)) u_vred (
    .clk(clk), .rst_n(rst_n), .start(red_start), .x(v_x), .done(red_done), .y(v_y)
  );

  mrfe_reduce #(.DIVISOR(MAX_SPLITS), .LANES(2)) u_sred (
    .clk(clk), .rst_n(rst_n), .start(red_start), .x(s_x), .done(red_s_done), .y(s_y)
  );

  logic [SW-1:0] s_idx;
  assign s_idx = SW'(s_y[0]);

  // sequencer
  state_t           st_r, st_nxt;
  req_t             req_r, req_nxt;
  logic             rv_in_r, rv_in_nxt;
  logic             hrs_r, hrs_nxt;
  logic             ph_r, ph_nxt;
  tgt_t             k_r, k_nxt, k_succ;
  logic             k_last;
  logic [VW-1:0]    cur_v_r, cur_v_nxt;
  logic [SW-1:0]    qs_r, qs_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [CLR_W-1:0] clr_r, clr_nxt;
  srec_t            srec_r, srec_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0] res_anc_r, res_anc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [IDX_W-1:0] out_anc_r, out_anc_nxt;
  logic [VW-1:0]    vaddr, tgt_v;
  vrec_t            vr;

  always_comb begin
    case (k_r)
      TGT_PARENT: tgt_v = srec_r.parent;
      TGT_LEFT:   tgt_v = srec_r.left;
      TGT_RIGHT:  tgt_v = srec_r.right;
      default:    tgt_v = srec_r.child;
    endcase
    vaddr  = (req_r == REQ_QUERY || req_r == REQ_LOAD_VERTEX) ? cur_v_r : tgt_v;
    k_last = (k_r == TGT_RIGHT) || (k_r == TGT_LEFT && !srec_r.rv);
    case (k_r)
      TGT_CHILD:  k_succ = TGT_PARENT;
      TGT_PARENT: k_succ = TGT_LEFT;
      default:    k_succ = TGT_RIGHT;
    endcase
  end

  always_comb begin
    st_nxt         = st_r;
    req_nxt        = req_r;
    rv_in_nxt      = rv_in_r;
    hrs_nxt        = hrs_r;
    ph_nxt         = ph_r;
    k_nxt          = k_r;
    cur_v_nxt      = cur_v_r;
    qs_nxt         = qs_r;
    steps_nxt      = steps_r;
    clr_nxt        = clr_r;
    srec_nxt       = srec_r;
    res_status_nxt = res_status_r;
    res_anc_nxt    = res_anc_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_anc_nxt    = out_anc_r;
    s_we = 1'b0;
    s_wa = s_idx;
    s_wd = '0;
    s_ra = s_idx;
    v_we = 1'b0;
    v_wa = vaddr;
    v_wd = '0;
    v_ra = vaddr;
    vr   = v_rd_r;
    case (st_r)
      S_CLEAR: begin
        s_we = (clr_r < MAX_SPLITS);
        s_wa = clr_r[SW-1:0];
        v_we = (clr_r < MAX_VERTICES);
        v_wa = clr_r[VW-1:0];
        if (clr_r == CLR_W'(CLR_N - 1)) begin
          st_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt     = req_t'(in_req_type);
          rv_in_nxt   = in_right_present;
          hrs_nxt     = in_has_removing_split;
          res_anc_nxt = '0;
          st_nxt      = S_RED;
        end
      end
      S_RED: begin
        if (red_done) begin
          cur_v_nxt = VW'(v_y[0]);
          steps_nxt = '0;
          case (req_r)
            REQ_LOAD_SPLIT, REQ_REFINE, REQ_COARSEN: st_nxt = S_SRD;
            REQ_LOAD_VERTEX, REQ_QUERY: st_nxt = S_VRD;
            default: begin
              res_status_nxt = STAT_DONE;
              st_nxt         = S_DONE;
            end
          endcase
        end
      end
      S_SRD: begin
        s_ra   = (req_r == REQ_QUERY) ? qs_r : s_idx;
        st_nxt = S_SDEC;
      end
      S_SDEC: begin
        srec_nxt = s_rd_r;
        case (req_r)
          REQ_LOAD_SPLIT: begin
            s_we = 1'b1;
            s_wd.parent  = VW'(v_y[1]);
            s_wd.left    = VW'(v_y[2]);
            s_wd.right   = VW'(v_y[3]);
            s_wd.child   = VW'(v_y[4]);
            s_wd.rv      = rv_in_r;
            s_wd.refined = s_rd_r.refined;
            res_status_nxt = STAT_DONE;
            st_nxt = S_DONE;
          end
          REQ_REFINE: begin
            if (s_rd_r.refined) begin
              res_status_nxt = STAT_SAME;
              st_nxt = S_DONE;
            end else begin
              ph_nxt = 1'b0;
              k_nxt  = TGT_PARENT;
              st_nxt = S_VRD;
            end
          end
          REQ_COARSEN: begin
            if (!s_rd_r.refined) begin
              res_status_nxt = STAT_SAME;
              st_nxt = S_DONE;
            end else begin
              ph_nxt = 1'b0;
              k_nxt  = TGT_CHILD;
              st_nxt = S_VRD;
            end
          end
          REQ_QUERY: begin
            cur_v_nxt = s_rd_r.parent;
            steps_nxt = STEP_W'(steps_r + 1'b1);
            st_nxt    = S_VRD;
          end
          default: begin
            res_status_nxt = STAT_DONE;
            st_nxt = S_DONE;
          end
        endcase
      end
      S_VRD: begin
        st_nxt = S_VCHK;
      end
      S_VCHK: begin
        v_wd = vr;
        case (req_r)
          REQ_LOAD_VERTEX: begin
            v_we = 1'b1;
            v_wd.rem_valid = hrs_r;
            v_wd.rem_idx   = hrs_r ? SW'(s_y[1]) : '0;
            v_wd.active    = !hrs_r;
            res_status_nxt = STAT_DONE;
            st_nxt = S_DONE;
          end
          REQ_REFINE, REQ_COARSEN: begin
            if (!ph_r) begin
              if (req_r == REQ_REFINE) begin
                if (!vr.active) begin
                  res_status_nxt = STAT_BLOCKED;
                  st_nxt = S_DONE;
                end else if (k_last) begin
                  st_nxt = S_SWR;
                end else begin
                  k_nxt  = k_succ;
                  st_nxt = S_VRD;
                end
              end else if (vr.dep != '0) begin
                res_status_nxt = STAT_BLOCKED;
                st_nxt = S_DONE;
              end else begin
                st_nxt = S_SWR;
              end
            end else begin
              v_we = 1'b1;
              if (k_r == TGT_CHILD) begin
                v_wd.active = (req_r == REQ_REFINE);
              end else if (req_r == REQ_REFINE) begin
                if (vr.dep != DEP_MAX) v_wd.dep = vr.dep + 1'b1;
              end else begin
                if (vr.dep != '0) v_wd.dep = vr.dep - 1'b1;
              end
              if (k_last) begin
                res_status_nxt = STAT_DONE;
                st_nxt = S_DONE;
              end else begin
                k_nxt  = k_succ;
                st_nxt = S_VRD;
              end
            end
          end
          REQ_QUERY: begin
            if (vr.active) begin
              res_status_nxt = STAT_DONE;
              res_anc_nxt    = IDX_W'(cur_v_r);
              st_nxt = S_DONE;
            end else if (!vr.rem_valid || steps_r >= MAX_SPLITS) begin
              res_status_nxt = STAT_LIMIT;
              st_nxt = S_DONE;
            end else begin
              qs_nxt = vr.rem_idx;
              st_nxt = S_SRD;
            end
          end
          default: begin
            res_status_nxt = STAT_DONE;
            st_nxt = S_DONE;
          end
        endcase
      end
      S_SWR: begin
        s_we = 1'b1;
        s_wd = srec_r;
        s_wd.refined = (req_r == REQ_REFINE);
        ph_nxt = 1'b1;
        k_nxt  = TGT_CHILD;
        st_nxt = S_VRD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_anc_nxt    = res_anc_r;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    rv_in_r      <= rv_in_nxt;
    hrs_r        <= hrs_nxt;
    ph_r         <= ph_nxt;
    k_r          <= k_nxt;
    cur_v_r      <= cur_v_nxt;
    qs_r         <= qs_nxt;
    steps_r      <= steps_nxt;
    srec_r       <= srec_nxt;
    res_status_r <= res_status_nxt;
    res_anc_r    <= res_anc_nxt;
    out_status_r <= out_status_nxt;
    out_anc_r    <= out_anc_nxt;
  end

  assign in_ready            = (st_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_ancestor_vertex = out_anc_r;

  // checks
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a request is in flight");

  a_anc_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_DONE |-> out_ancestor_vertex == '0)
    else $error("ancestor reported with a failing status");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready before the clearing pass");

  a_reduce_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    red_done |-> st_r == S_RED && red_s_done)
    else $error("index reduction finished outside its step");

endmodule
